// ----- rtl/fpt_pkg.sv -----
package fpt_pkg;

  // Pool geometry
  localparam int TableFrames = 64;
  localparam int Entries     = 512;
  localparam int FrameW      = $clog2(TableFrames);
  localparam int IdxW        = $clog2(Entries);
  localparam int AddrW       = FrameW + IdxW;
  localparam int Depth       = TableFrames * Entries;
  localparam int NffW        = $clog2(TableFrames + 1);
  localparam int ClrW        = $clog2(Depth + 1);

  // Field widths
  localparam int CmdW   = 2;
  localparam int VpnW   = 36;
  localparam int PpnW   = 40;
  localparam int FlagW  = 12;
  localparam int StatW  = 3;
  localparam int EntryW = 64;

  typedef enum logic [CmdW-1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK          = 3'd0,
    ST_DUP         = 3'd1,
    ST_MISS4       = 3'd2,
    ST_MISS3       = 3'd3,
    ST_MISS2       = 3'd4,
    ST_LEAF_ABSENT = 3'd5,
    ST_EXHAUSTED   = 3'd6,
    ST_RSVD        = 3'd7
  } status_e;

  // Store access from the walker
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
    logic              re;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

  // Result word from the walker
  typedef struct packed {
    logic             valid;
    logic [StatW-1:0] status;
    logic             is_mapped;
  } result_t;

endpackage

// ----- rtl/four_level_page_table_manager.sv -----
// Channel   Dir  Word fields (low bit up)
// s_axis    in   tdata: cmd[1:0] virt_page[37:2] phys_page[77:38] page_flags[89:78]
// m_axis    out  tdata: status[2:0] is_mapped[3]
//
// One request at a time: accept, then read each table level from the
// store in turn (up to four), then the result word.
// The store read port latency sets the one-level-per-cycle walk.
// After reset a clearing pass zeroes the 32768-entry store, one entry a
// cycle, with s_axis_tready_o low.
// A result waiting on m_axis holds off the next request.
module four_level_page_table_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,  // cmd, virt_page, phys_page, page_flags
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // status, is_mapped
);
  import fpt_pkg::*;

  mem_req_t          req;
  result_t           res;
  logic [EntryW-1:0] rdata;
  logic              store_ready, walk_idle, start;
  logic              ovalid_q, ovalid_d;
  logic [StatW-1:0]  ostat_q;
  logic              omap_q;

  assign s_axis_tready_o = store_ready && walk_idle && !ovalid_q;
  assign start           = s_axis_tvalid_i && s_axis_tready_o;

  fpt_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata),
    .ready_o (store_ready)
  );

  fpt_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (s_axis_tdata_i[1:0]),
    .vpn_i   (s_axis_tdata_i[37:2]),
    .ppn_i   (s_axis_tdata_i[77:38]),
    .flags_i (s_axis_tdata_i[89:78]),
    .rdata_i (rdata),
    .req_o   (req),
    .res_o   (res),
    .idle_o  (walk_idle)
  );

  // Output register
  assign ovalid_d = res.valid || (ovalid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      ostat_q <= res.status;
      omap_q  <= res.is_mapped;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {4'b0000, omap_q, ostat_q};

endmodule

// ----- rtl/fpt_store.sv -----
module fpt_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fpt_pkg::mem_req_t        req_i,
  output logic [fpt_pkg::EntryW-1:0] rdata_o,
  output logic                     ready_o
);
  import fpt_pkg::*;

  logic [EntryW-1:0] mem [Depth];
  logic [ClrW-1:0]   clr_q, clr_d;
  logic              clearing;

  assign clearing = (clr_q < ClrW'(Depth));
  assign ready_o  = ~clearing;
  assign clr_d    = clearing ? clr_q + ClrW'(1) : clr_q;

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_q[AddrW-1:0]] <= '0;
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

// ----- rtl/fpt_walk.sv -----
module fpt_walk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fpt_pkg::CmdW-1:0]   cmd_i,
  input  logic [fpt_pkg::VpnW-1:0]   vpn_i,
  input  logic [fpt_pkg::PpnW-1:0]   ppn_i,
  input  logic [fpt_pkg::FlagW-1:0]  flags_i,
  input  logic [fpt_pkg::EntryW-1:0] rdata_i,
  output fpt_pkg::mem_req_t          req_o,
  output fpt_pkg::result_t           res_o,
  output logic                       idle_o
);
  import fpt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        level_q, level_d;
  logic [NffW-1:0]   nff_q, nff_d;
  logic [CmdW-1:0]   cmd_q;
  logic [VpnW-1:0]   vpn_q;
  logic [PpnW-1:0]   ppn_q;
  logic [FlagW-1:0]  flags_q;
  logic [AddrW-1:0]  slot_q, slot_d;
  logic              present, ptr_ok;
  logic [1:0]        nlevel;

  function automatic logic [IdxW-1:0] idx_of(logic [VpnW-1:0] v, logic [1:0] l);
    logic [IdxW-1:0] r;
    unique case (l)
      2'd3:    r = v[3*IdxW +: IdxW];
      2'd2:    r = v[2*IdxW +: IdxW];
      2'd1:    r = v[IdxW +: IdxW];
      default: r = v[0 +: IdxW];
    endcase
    return r;
  endfunction

  assign present = rdata_i[0];
  assign ptr_ok  = present && (rdata_i[EntryW-1:12] < (EntryW-12)'(TableFrames));
  assign nlevel  = level_q - 2'd1;
  assign idle_o  = (state_q == S_IDLE);

  // Sequencer: one level per cycle, read data is registered and arrives in the cycle after issue
  always_comb begin
    state_d = state_q;
    level_d = level_q;
    nff_d   = nff_q;
    slot_d  = slot_q;
    req_o   = '0;
    res_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (cmd_e'(cmd_i) == CMD_NONE) begin
            res_o.valid  = 1'b1;
            res_o.status = ST_OK;
          end else begin
            req_o.re    = 1'b1;
            req_o.raddr = {FrameW'(0), idx_of(vpn_i, 2'd3)};
            slot_d      = req_o.raddr;
            level_d     = 2'd3;
            state_d     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (level_q != 2'd0) begin
          if (ptr_ok) begin
            req_o.re    = 1'b1;
            req_o.raddr = {rdata_i[12 +: FrameW], idx_of(vpn_q, nlevel)};
            slot_d      = req_o.raddr;
            level_d     = nlevel;
          end else if (cmd_e'(cmd_q) == CMD_MAP) begin
            if (nff_q >= NffW'(TableFrames)) begin
              res_o.valid  = 1'b1;
              res_o.status = ST_EXHAUSTED;
              state_d      = S_IDLE;
            end else begin
              // Link a fresh frame and read into it
              req_o.we    = 1'b1;
              req_o.waddr = slot_q;
              req_o.wdata = (EntryW'(nff_q) << 12) | EntryW'(3);
              req_o.re    = 1'b1;
              req_o.raddr = {nff_q[FrameW-1:0], idx_of(vpn_q, nlevel)};
              slot_d      = req_o.raddr;
              nff_d       = nff_q + NffW'(1);
              level_d     = nlevel;
            end
          end else begin
            // Missing table: check reports only through is_mapped, unmap gets a miss status by level
            res_o.valid = 1'b1;
            state_d     = S_IDLE;
            if (cmd_e'(cmd_q) == CMD_CHECK) begin
              res_o.status = ST_OK;
            end else begin
              res_o.status = StatW'(ST_MISS4) + StatW'(2'd3 - level_q);
            end
          end
        end else begin
          // Leaf entry
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
          case (cmd_e'(cmd_q))
            CMD_MAP: begin
              if (present) begin
                res_o.status = ST_DUP;
              end else begin
                res_o.status = ST_OK;
                req_o.we     = 1'b1;
                req_o.waddr  = slot_q;
                req_o.wdata  = (EntryW'(ppn_q) << 12) | EntryW'(flags_q) | EntryW'(3);
              end
            end
            CMD_UNMAP: begin
              if (present) begin
                res_o.status = ST_OK;
                req_o.we     = 1'b1;
                req_o.waddr  = slot_q;
                req_o.wdata  = {rdata_i[EntryW-1:1], 1'b0};
              end else begin
                res_o.status = ST_LEAF_ABSENT;
              end
            end
            default: begin
              res_o.status    = ST_OK;
              res_o.is_mapped = present;
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      level_q <= 2'd0;
      nff_q   <= NffW'(1);
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      nff_q   <= nff_d;
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (start_i && idle_o) begin
      cmd_q   <= cmd_i;
      vpn_q   <= vpn_i;
      ppn_q   <= ppn_i;
      flags_q <= flags_i;
    end
  end

endmodule
